/* hdl/tun_pkg.sv */
// Package for the triangle unit normal block: widths and shared constants.
// No dependencies; imported by triangle_unit_normal and its checker.
`timescale 1ns / 1ps
package tun_pkg;
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int FIELD_WIDTH       = 16;
    localparam int OUT_WIDTH         = 16;
    localparam int IN_TDATA_WIDTH    = 9 * FIELD_WIDTH;
    localparam int OUT_TDATA_WIDTH   = 3 * OUT_WIDTH;
endpackage

/* hdl/triangle_unit_normal.sv */
// Triangle unit normal: pipelined cross product, integer square root and
// restoring divisions. Depends on tun_pkg.
// Pipeline: 2*CW + OUT_FRAC_BITS + 11 register stages (57 with defaults): six front
// stages, 2*CW+3 root stages, OUT_FRAC_BITS+1 quotient stages and the output register.
// Throughput: one triangle per cycle; the pipeline advances whenever the
// output register is free or being drained; each root and quotient bit has its
// own stage. Depth is set by the bit-per-stage square root and divider.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
module triangle_unit_normal #(
    parameter int COORD_WIDTH   = tun_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // first_x, first_y, first_z, second_x..z, third_x..z, 16 bits each from bit 0
    input  logic [tun_pkg::IN_TDATA_WIDTH-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // normal_x, normal_y, normal_z, 16 bits each from bit 0
    output logic [tun_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
    // degenerate
    output logic m_tuser
);
    import tun_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;          // edge width
    localparam int PW  = 2 * DW;          // product width
    localparam int CCW = PW + 1;          // cross component width (signed)
    localparam int MW  = PW;              // magnitude width
    localparam int SW  = 2 * MW + 2;      // sum of squares width
    localparam int RW  = SW / 2;          // root width
    localparam int F   = OUT_FRAC_BITS;
    localparam int QW  = F + 2;
    localparam int NQ  = F + 1;           // quotient bits
    localparam int NS  = RW + NQ + 7;     // total pipeline stages

    logic adv;
    logic [NS-1:0] v_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 0: edges
    logic signed [DW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    function automatic logic signed [DW-1:0] fld(input logic [IN_TDATA_WIDTH-1:0] d,
                                                 input int i);
        logic signed [CW-1:0] t;
        t = CW'(d[i*FIELD_WIDTH +: FIELD_WIDTH]);
        return DW'(t);
    endfunction
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg <= fld(s_tdata, 0) - fld(s_tdata, 3);
            ay_reg <= fld(s_tdata, 1) - fld(s_tdata, 4);
            az_reg <= fld(s_tdata, 2) - fld(s_tdata, 5);
            bx_reg <= fld(s_tdata, 0) - fld(s_tdata, 6);
            by_reg <= fld(s_tdata, 1) - fld(s_tdata, 7);
            bz_reg <= fld(s_tdata, 2) - fld(s_tdata, 8);
        end
    end

    // stage 1: six products
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_reg <= ay_reg * bz_reg;
            p1_reg <= az_reg * by_reg;
            p2_reg <= az_reg * bx_reg;
            p3_reg <= ax_reg * bz_reg;
            p4_reg <= ax_reg * by_reg;
            p5_reg <= ay_reg * bx_reg;
        end
    end

    // stage 2: cross product
    logic signed [CCW-1:0] c_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg[0] <= CCW'(p0_reg) - CCW'(p1_reg);
            c_reg[1] <= CCW'(p2_reg) - CCW'(p3_reg);
            c_reg[2] <= CCW'(p4_reg) - CCW'(p5_reg);
        end
    end

    // stage 3: magnitudes and signs
    logic [MW-1:0] m_reg [3];
    logic [2:0]    sg_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                m_reg[k]  <= c_reg[k][CCW-1] ? MW'(-c_reg[k]) : MW'(c_reg[k]);
                sg_reg[k] <= c_reg[k][CCW-1];
            end
        end
    end

    // stage 4: squares
    logic [2*MW-1:0] sq_reg [3];
    logic [MW-1:0]   m4_reg [3];
    logic [2:0]      sg4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= m_reg[k] * m_reg[k];
            end
            m4_reg  <= m_reg;
            sg4_reg <= sg_reg;
        end
    end

    // stage 5: sum of squares
    logic [SW-1:0] sum_reg;
    logic [MW-1:0] m5_reg [3];
    logic [2:0]    sg5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            m5_reg  <= m4_reg;
            sg5_reg <= sg4_reg;
        end
    end

    // square root stages: one root bit each, remainder form (restoring)
    logic [SW-1:0] sr_n_reg  [RW+1];
    logic [RW-1:0] sr_q_reg  [RW+1];
    logic [SW+1:0] sr_r_reg  [RW+1];
    logic [MW-1:0] sr_m_reg  [RW+1][3];
    logic [2:0]    sr_s_reg  [RW+1];
    always_comb begin
        sr_n_reg[0] = sum_reg;
        sr_q_reg[0] = '0;
        sr_r_reg[0] = '0;
        sr_m_reg[0] = m5_reg;
        sr_s_reg[0] = sg5_reg;
    end
    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        logic [SW+1:0] rs, tr;
        always_comb begin
            rs = {sr_r_reg[i][SW-1:0], sr_n_reg[i][SW-1 -: 2]};
            tr = rs - {(SW+2-RW-2)'(0), sr_q_reg[i], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sr_n_reg[i+1] <= {sr_n_reg[i][SW-3:0], 2'b00};
                if (!tr[SW+1]) begin
                    sr_r_reg[i+1] <= tr;
                    sr_q_reg[i+1] <= {sr_q_reg[i][RW-2:0], 1'b1};
                end else begin
                    sr_r_reg[i+1] <= rs;
                    sr_q_reg[i+1] <= {sr_q_reg[i][RW-2:0], 1'b0};
                end
                sr_m_reg[i+1] <= sr_m_reg[i];
                sr_s_reg[i+1] <= sr_s_reg[i];
            end
        end
    end

    // divider stages: per component restoring division, one quotient bit each
    logic [RW-1:0] len [NQ+1];
    logic [RW:0]   dr  [NQ+1][3];
    logic [QW-1:0] dq  [NQ+1][3];
    logic [2:0]    ds  [NQ+1];
    always_comb begin
        len[0] = sr_q_reg[RW];
        ds[0]  = sr_s_reg[RW];
        for (int k = 0; k < 3; k++) begin
            dr[0][k] = (RW+1)'(sr_m_reg[RW][k]);
            dq[0][k] = '0;
        end
    end
    for (genvar i = 0; i < NQ; i++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv) begin
                len[i+1] <= len[i];
                ds[i+1]  <= ds[i];
                for (int k = 0; k < 3; k++) begin
                    if (dr[i][k] >= (RW+1)'(len[i])) begin
                        dr[i+1][k] <= (((RW+1)'(dr[i][k] - (RW+1)'(len[i]))) << (i < NQ-1));
                        dq[i+1][k] <= {dq[i][k][QW-2:0], 1'b1};
                    end else begin
                        dr[i+1][k] <= dr[i][k] << (i < NQ-1);
                        dq[i+1][k] <= {dq[i][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // final stage: rounding, saturation, sign, degenerate
    logic [OUT_TDATA_WIDTH-1:0] od_reg;
    logic                       og_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            og_reg <= (len[NQ] == '0);
            for (int k = 0; k < 3; k++) begin
                logic [QW-1:0]   q;
                logic signed [QW:0] s;
                q = dq[NQ][k];
                if (dr[NQ][k] >= (RW+1)'(len[NQ]) - dr[NQ][k]) q = q + QW'(1);
                if (q > QW'(1) << F) q = QW'(1) << F;
                s = ds[NQ][k] ? -$signed({1'b0, q}) : $signed({1'b0, q});
                if (len[NQ] == '0) s = '0;
                od_reg[k*OUT_WIDTH +: OUT_WIDTH] <= OUT_WIDTH'(s);
            end
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], s_tvalid};
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = od_reg;
    assign m_tuser  = og_reg;
endmodule

/* hdl/tun_checker.sv */
// Port-level checker for triangle_unit_normal, attached by bind.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [tun_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
    input logic m_tuser
);
    import tun_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // degenerate transactions carry a zero vector
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result not zero");

    // input side is ready whenever output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

/* tb/testbench.sv */
// Testbench for triangle_unit_normal: random and directed triangles, results
// checked against an in-bench fixed-point normal predictor. Depends on tun_pkg.
`timescale 1ns / 1ps

class normal_scoreboard;
    logic [tun_pkg::OUT_TDATA_WIDTH-1:0] exp_normal_q[$];
    logic                                exp_degen_q[$];
    int                                  mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Expected normal of one triangle: cross product, floor root, rounded scale
    function void note_triangle(logic [tun_pkg::IN_TDATA_WIDTH-1:0] tri_data);
        logic signed [16:0] ax, ay, az, bx, by, bz;
        logic signed [35:0] cr[3];
        logic [35:0]        mag;
        logic [72:0]        sumsq;
        logic [36:0]        root, cand;
        logic [63:0]        quo, rem;
        logic [15:0]        comp[3];
        logic signed [15:0] v[9];
        for (int i = 0; i < 9; i++) v[i] = tri_data[16*i +: 16];
        ax = v[0] - v[3]; ay = v[1] - v[4]; az = v[2] - v[5];
        bx = v[0] - v[6]; by = v[1] - v[7]; bz = v[2] - v[8];
        cr[0] = ay * bz - az * by;
        cr[1] = az * bx - ax * bz;
        cr[2] = ax * by - ay * bx;
        sumsq = 0;
        for (int k = 0; k < 3; k++) begin
            mag = cr[k] < 0 ? -cr[k] : cr[k];
            sumsq += mag * mag;
        end
        root = 0;
        for (int b = 36; b >= 0; b--) begin
            cand = root | (37'd1 << b);
            if ({37'd0, cand} * {37'd0, cand} <= {1'b0, sumsq}) root = cand;
        end
        if (root == 0) begin
            exp_normal_q.push_back('0);
            exp_degen_q.push_back(1'b1);
            return;
        end
        for (int k = 0; k < 3; k++) begin
            mag = cr[k] < 0 ? -cr[k] : cr[k];
            quo = ({28'd0, mag} << 14) / root;
            rem = ({28'd0, mag} << 14) % root;
            if (rem >= root - rem) quo++;
            if (quo > 64'd16384) quo = 64'd16384;
            comp[k] = cr[k] < 0 ? -quo[15:0] : quo[15:0];
        end
        exp_normal_q.push_back({comp[2], comp[1], comp[0]});
        exp_degen_q.push_back(1'b0);
    endfunction

    function void check_normal(logic [tun_pkg::OUT_TDATA_WIDTH-1:0] got,
                               logic got_degen);
        logic [tun_pkg::OUT_TDATA_WIDTH-1:0] want;
        logic                                want_degen;
        if (exp_normal_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h/%b", got, got_degen);
            return;
        end
        want = exp_normal_q.pop_front();
        want_degen = exp_degen_q.pop_front();
        for (int k = 0; k < 3; k++)
            if (got[16*k +: 16] !== want[16*k +: 16]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("normal[%0d] expected %0d got %0d", k,
                             $signed(want[16*k +: 16]), $signed(got[16*k +: 16]));
            end
        if (got_degen !== want_degen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("degenerate expected %b got %b", want_degen, got_degen);
        end
    endfunction
endclass

module testbench;
    logic                                aclk = 0;
    logic                                aresetn = 0;
    logic                                s_tvalid = 0;
    logic                                s_tready;
    logic [tun_pkg::IN_TDATA_WIDTH-1:0]  s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 0;
    logic [tun_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;
    logic                                m_tuser;

    localparam int LATENCY = 2 * 16 + 14 + 11;
    localparam int STALL_LIMIT = 5000;

    normal_scoreboard sb = new();
    int send_idle_pct = 36;
    int recv_idle_pct = 48;
    int stall_cycles = 0;

    triangle_unit_normal u_dut (.*);

    always #6 aclk = ~aclk;

    // Receiver: random backpressure, check each accepted transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_normal(m_tdata, m_tuser);
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // tvalid stays high between back-to-back transactions; it drops only to idle
    task automatic send_triangle(logic [tun_pkg::IN_TDATA_WIDTH-1:0] tri_data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1;
        s_tdata  <= tri_data;
        do @(posedge aclk); while (!s_tready);
        sb.note_triangle(tri_data);
    endtask

    task automatic send_coords(logic signed [15:0] p[9]);
        logic [tun_pkg::IN_TDATA_WIDTH-1:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = p[i];
        send_triangle(d);
    endtask

    // Full-range, random-span, collinear and near-extreme triangles, one case in four each
    task automatic send_random_triangle();
        logic [tun_pkg::IN_TDATA_WIDTH-1:0] d;
        logic signed [15:0] p[9];
        int span;
        case ($urandom_range(3))
            0: begin
                for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom);
                send_triangle(d);
            end
            1: begin
                span = 1 << $urandom_range(1, 15);
                for (int i = 0; i < 9; i++)
                    p[i] = 16'(int'($urandom_range(span - 1)) - span / 2);
                send_coords(p);
            end
            2: begin
                // collinear: p2 = p0 + k*(p1 - p0)
                for (int i = 0; i < 6; i++) p[i] = 16'(int'($urandom_range(200)) - 100);
                span = int'($urandom_range(4)) - 2;
                for (int i = 0; i < 3; i++)
                    p[6+i] = 16'(int'(p[i]) + span * (int'(p[3+i]) - int'(p[i])));
                send_coords(p);
            end
            default: begin
                for (int i = 0; i < 9; i++) p[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                if ($urandom_range(1)) p[$urandom_range(8)] = 16'($urandom);
                send_coords(p);
            end
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.exp_normal_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic signed [15:0] p[9];
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: degenerate, axis-aligned, extremes
        p = '{default: 0};                          send_coords(p);
        p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};           send_coords(p);
        p = '{0, 0, 0, 0, 1, 0, 1, 0, 0};           send_coords(p);
        p = '{0, 0, 0, 0, 0, 1, 1, 0, 0};           send_coords(p);
        p = '{0, 0, 0, 1, 1, 1, 2, 2, 2};           send_coords(p);
        p = '{5, 5, 5, 5, 5, 5, 9, 1, 3};           send_coords(p);
        p = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        send_coords(p);
        p = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        send_coords(p);
        p = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768};
        send_coords(p);
        p = '{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767};
        send_coords(p);
        p = '{0, 0, 0, 1, 2, 3, 3, 1, 2};           send_coords(p);
        p = '{0, 0, 0, 1, 1, 0, 1, 0, 1};           send_coords(p);
        p = '{0, 0, 0, 16'shffff, 16'shffff, 16'shffff, 1, 1, 16'shffff};
        send_coords(p);

        // Hold off until the pipeline is empty
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 36 : phase == 1 ? 48 : 0;
            recv_idle_pct = phase == 0 ? 48 : phase == 1 ? 36 : 0;
            for (int n = 0; n < 480; n++) send_random_triangle();
        end

        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.exp_normal_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

/* triangle_unit_normal.f */
hdl/tun_pkg.sv
hdl/triangle_unit_normal.sv
hdl/tun_checker.sv
tb/testbench.sv
